>>> hdl/ste3b_pkg.sv
package ste3b_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int POLE_FRAC      = 23;
  localparam int GAIN_FRAC      = 20;
  localparam int COEF_BITS      = 24;
  localparam int POLE_BITS      = 23;
  localparam int GAIN_BITS      = 23;
  localparam int OUT_GAIN_BITS  = 21;
  localparam int CFG_DATA_BITS  = 23;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_POLE    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_POLE   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_GAIN    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_GAIN   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OUTPUT_GAIN = 3'd4;

  localparam logic [POLE_BITS-1:0]     LOW_POLE_RESET    = 23'd8142000;
  localparam logic [POLE_BITS-1:0]     HIGH_POLE_RESET   = 23'd6200000;
  localparam logic [GAIN_BITS-1:0]     LOW_GAIN_RESET    = 23'd1480000;
  localparam logic [GAIN_BITS-1:0]     HIGH_GAIN_RESET   = 23'd1480000;
  localparam logic [OUT_GAIN_BITS-1:0] OUTPUT_GAIN_RESET = 21'd742000;

  localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << POLE_FRAC;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t left_sample;
    sample_t right_sample;
  } sample_pair_t;

  typedef struct packed {
    sample_t left_result;
    sample_t right_result;
  } result_pair_t;

endpackage

>>> hdl/stereo_three_band_enhancer_top.sv
// Each item runs 5 multiplies per channel, left then right. Each multiply makes a
// low-half and a high-half pass through the shared split multiplier, then updates.
// sample_stall stays high while an item runs, so items do not overlap.
// A finished result waits in the output register while the next item is accepted.
// Reset (rst, synchronous, active high) clears the four filter states, loads the
// register defaults and empties the output register.
module stereo_three_band_enhancer_top
  import ste3b_pkg::*;
#(
  parameter int ACC_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sample_valid,
  output logic                      sample_stall,
  input  sample_pair_t              sample,
  output logic                      result_valid,
  input  logic                      result_stall,
  output result_pair_t              result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int W         = ACC_BITS;
  localparam int EXTRA     = W - SAMPLE_BITS;
  localparam int OPW       = W + 5;
  localparam int RW        = W + 6;
  localparam int LOW_BITS  = (OPW + 1) / 2;
  localparam int HIGH_BITS = OPW - LOW_BITS;
  localparam int MULA      = LOW_BITS + 1;
  localparam int MULB      = COEF_BITS + 1;
  localparam int PW        = MULA + MULB;
  localparam int AW        = OPW + COEF_BITS + 1;

  localparam logic signed [AW-1:0] HALF_POLE  = AW'(1) << (POLE_FRAC - 1);
  localparam logic signed [AW-1:0] HALF_GAIN  = AW'(1) << (GAIN_FRAC - 1);
  localparam logic signed [RW:0]   EXTRA_HALF = ((RW + 1)'(1) << EXTRA) >> 1;
  localparam logic signed [RW-1:0] W_MAX      = (RW'(1) << (W - 1)) - RW'(1);
  localparam logic signed [RW-1:0] W_MIN      = -W_MAX - RW'(1);
  localparam logic signed [RW:0]   S_MAX      = ((RW + 1)'(1) << (SAMPLE_BITS - 1)) - (RW + 1)'(1);
  localparam logic signed [RW:0]   S_MIN      = -S_MAX - (RW + 1)'(1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  localparam logic [1:0] PH_LO   = 2'd0;
  localparam logic [1:0] PH_HI   = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  localparam logic [2:0] OP_LOW_LP    = 3'd0;
  localparam logic [2:0] OP_SPLIT_LP  = 3'd1;
  localparam logic [2:0] OP_LOW_GAIN  = 3'd2;
  localparam logic [2:0] OP_HIGH_GAIN = 3'd3;
  localparam logic [2:0] OP_OUT_GAIN  = 3'd4;

  logic                      state;
  logic                      chan;
  logic [2:0]                op;
  logic [1:0]                phase;
  sample_pair_t              in_reg;
  logic signed [W-1:0]       low_acc [2];
  logic signed [W-1:0]       split_acc [2];
  logic signed [OPW-1:0]     sum;
  sample_t                   left_res;
  logic signed [AW-1:0]      acc;

  logic [POLE_BITS-1:0]      low_pole;
  logic [POLE_BITS-1:0]      high_pole;
  logic [GAIN_BITS-1:0]      low_gain;
  logic [GAIN_BITS-1:0]      high_gain;
  logic [OUT_GAIN_BITS-1:0]  output_gain;

  sample_t                   smp;
  logic signed [W-1:0]       s_w;
  logic signed [W-1:0]       y_low;
  logic signed [W-1:0]       y_split;
  logic signed [W-1:0]       y_filt;
  logic signed [OPW-1:0]     operand;
  logic [COEF_BITS-1:0]      coef;
  logic                      is_pole;
  logic signed [HIGH_BITS-1:0] hi_part;
  logic signed [MULA-1:0]    mul_a;
  logic signed [MULB-1:0]    mul_b;
  logic signed [PW-1:0]      product;
  logic signed [AW-1:0]      half_sel;
  logic signed [AW-1:0]      rnd_full;
  logic signed [RW-1:0]      rnd;
  logic signed [RW-1:0]      filt_sum;
  logic signed [W-1:0]       y_new;
  logic signed [RW-1:0]      mid_sum;
  logic signed [RW-1:0]      high_sum;
  logic signed [RW:0]        fin_wide;
  sample_t                   fin_sat;
  logic                      res_load;

  assign sample_stall = (state != ST_IDLE);
  assign cfg_ready    = 1'b1;

  assign smp     = chan ? in_reg.right_sample : in_reg.left_sample;
  assign s_w     = W'(smp) <<< EXTRA;
  assign y_low   = low_acc[chan];
  assign y_split = split_acc[chan];

  always_comb begin
    unique case (op)
      OP_LOW_LP: begin
        operand = OPW'(s_w) - OPW'(y_low);
        coef    = COEF_ONE - {1'b0, low_pole};
        is_pole = 1'b1;
      end
      OP_SPLIT_LP: begin
        operand = OPW'(s_w) - OPW'(y_split);
        coef    = COEF_ONE - {1'b0, high_pole};
        is_pole = 1'b1;
      end
      OP_LOW_GAIN: begin
        operand = OPW'(y_low);
        coef    = {1'b0, low_gain};
        is_pole = 1'b0;
      end
      OP_HIGH_GAIN: begin
        operand = OPW'(s_w) - OPW'(y_split);
        coef    = {1'b0, high_gain};
        is_pole = 1'b0;
      end
      OP_OUT_GAIN: begin
        operand = sum;
        coef    = COEF_BITS'(output_gain);
        is_pole = 1'b0;
      end
      default: begin
        operand = '0;
        coef    = '0;
        is_pole = 1'b0;
      end
    endcase
  end

  assign hi_part  = operand[OPW-1:LOW_BITS];
  assign mul_a    = (phase == PH_LO) ? $signed({1'b0, operand[LOW_BITS-1:0]}) : MULA'(hi_part);
  assign mul_b    = $signed({1'b0, coef});
  assign product  = mul_a * mul_b;
  assign half_sel = is_pole ? HALF_POLE : HALF_GAIN;

  assign rnd_full = is_pole ? (acc >>> POLE_FRAC) : (acc >>> GAIN_FRAC);
  assign rnd      = RW'(rnd_full);

  assign y_filt   = (op == OP_LOW_LP) ? y_low : y_split;
  assign filt_sum = RW'(y_filt) + rnd;

  always_comb begin
    priority if (filt_sum > W_MAX) begin
      y_new = W'(W_MAX);
    end else if (filt_sum < W_MIN) begin
      y_new = W'(W_MIN);
    end else begin
      y_new = W'(filt_sum);
    end
  end

  assign mid_sum  = rnd + RW'(y_split) - RW'(y_low);
  assign high_sum = RW'(sum) + rnd;
  assign fin_wide = ((RW + 1)'(rnd) + EXTRA_HALF) >>> EXTRA;

  always_comb begin
    priority if (fin_wide > S_MAX) begin
      fin_sat = SAMPLE_BITS'(S_MAX);
    end else if (fin_wide < S_MIN) begin
      fin_sat = SAMPLE_BITS'(S_MIN);
    end else begin
      fin_sat = SAMPLE_BITS'(fin_wide);
    end
  end

  assign res_load = (state != ST_IDLE) && (phase == PH_DONE) && (op == OP_OUT_GAIN)
                    && chan && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      chan         <= 1'b0;
      op           <= OP_LOW_LP;
      phase        <= PH_LO;
      result_valid <= 1'b0;
      low_acc[0]   <= '0;
      low_acc[1]   <= '0;
      split_acc[0] <= '0;
      split_acc[1] <= '0;
      low_pole     <= LOW_POLE_RESET;
      high_pole    <= HIGH_POLE_RESET;
      low_gain     <= LOW_GAIN_RESET;
      high_gain    <= HIGH_GAIN_RESET;
      output_gain  <= OUTPUT_GAIN_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_LOW_POLE:    low_pole    <= cfg_data[POLE_BITS-1:0];
          REG_HIGH_POLE:   high_pole   <= cfg_data[POLE_BITS-1:0];
          REG_LOW_GAIN:    low_gain    <= cfg_data[GAIN_BITS-1:0];
          REG_HIGH_GAIN:   high_gain   <= cfg_data[GAIN_BITS-1:0];
          REG_OUTPUT_GAIN: output_gain <= cfg_data[OUT_GAIN_BITS-1:0];
          default: ;
        endcase
      end

      priority if (res_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            in_reg <= sample;
            state  <= ST_RUN;
            chan   <= 1'b0;
            op     <= OP_LOW_LP;
            phase  <= PH_LO;
          end
        end
        default: begin
          unique case (phase)
            PH_LO: begin
              acc   <= AW'(product) + half_sel;
              phase <= PH_HI;
            end
            PH_HI: begin
              acc   <= acc + (AW'(product) <<< LOW_BITS);
              phase <= PH_DONE;
            end
            default: begin
              unique case (op)
                OP_LOW_LP:    low_acc[chan]   <= y_new;
                OP_SPLIT_LP:  split_acc[chan] <= y_new;
                OP_LOW_GAIN:  sum             <= OPW'(mid_sum);
                OP_HIGH_GAIN: sum             <= OPW'(high_sum);
                default: ;
              endcase
              if (op == OP_OUT_GAIN) begin
                if (!chan) begin
                  left_res <= fin_sat;
                  chan     <= 1'b1;
                  op       <= OP_LOW_LP;
                  phase    <= PH_LO;
                end else if (res_load) begin
                  result.left_result  <= left_res;
                  result.right_result <= fin_sat;
                  state               <= ST_IDLE;
                end
              end else begin
                op    <= op + 3'd1;
                phase <= PH_LO;
              end
            end
          endcase
        end
      endcase
    end
  end

endmodule
